### hdl/extendible_hash_join_table_unit_assert.svh
// Assertion macros for the extendible hash join table unit
`ifndef EXTENDIBLE_HASH_JOIN_TABLE_UNIT_ASSERT_SVH
`define EXTENDIBLE_HASH_JOIN_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define EHJ_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EHJ_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ehj_pkg.sv
// Package: constants, types and helpers of the extendible hash join table
package ehj_pkg;

    localparam int BUCKET_SLOTS_DEF  = 8;
    localparam int MAX_DEPTH_DEF     = 10;
    localparam int BUCKET_POOL_DEF   = 1024;
    localparam int INITIAL_DEPTH_DEF = 2;
    localparam int MAX_RESULTS       = 8;

    // result status codes
    localparam logic [2:0] STS_INSERTED = 3'd0;
    localparam logic [2:0] STS_MATCH    = 3'd1;
    localparam logic [2:0] STS_NOMATCH  = 3'd2;
    localparam logic [2:0] STS_DEPTH    = 3'd3;
    localparam logic [2:0] STS_POOL     = 3'd4;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_PROBE  = 1'b1;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_RETRY,
        ST_DIR,
        ST_BKT,
        ST_GROW_RD,
        ST_GROW_WT,
        ST_GROW_INC,
        ST_SCAN_RD,
        ST_SCAN_WT,
        ST_LOAD_RD,
        ST_LOAD_WT,
        ST_RESET_B,
        ST_RH_START,
        ST_RH_WAIT,
        ST_RH_DIR,
        ST_RH_BKT,
        ST_PROBE_RD,
        ST_PROBE_CMP,
        ST_PROBE_FIN
    } t_state;

    // hash unit response
    typedef struct packed {
        logic        done;
        logic [31:0] hash;
    } t_hash_rsp;

    // starting depth, lowered until it fits the directory and the pool
    function automatic int fit_depth(input int init_d, input int max_d, input int pool);
        int d;
        d = (init_d > max_d) ? max_d : init_d;
        while (d > 0 && (1 << d) > pool) d = d - 1;
        return d;
    endfunction

endpackage

### hdl/ehj_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port
module ehj_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_wa,
    input  logic [DW-1:0] i_wd,
    input  logic          i_re,
    input  logic [AW-1:0] i_ra,
    output logic [DW-1:0] o_rd
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rd;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wa] <= i_wd;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd <= mem[i_ra];
        end
    end

    assign o_rd = r_rd;

endmodule

### hdl/ehj_hash.sv
// Byte-serial sdbm hash unit, one byte per cycle, stops at the first zero byte
module ehj_hash (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_key,
    output ehj_pkg::t_hash_rsp o_rsp
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [31:0] r_k, n_k;
    logic [31:0] r_h, n_h;

    // one hash step per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_k    = r_k;
        n_h    = r_h;
        if (i_start) begin
            n_busy = 1'b1;
            n_k    = i_key;
            n_h    = '0;
        end else if (r_busy) begin
            if (r_k[7:0] == 8'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_h = {24'd0, r_k[7:0]} + (r_h << 6) + (r_h << 16) - r_h;
                n_k = {8'd0, r_k[31:8]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_k <= n_k;
        r_h <= n_h;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.hash = r_h;

endmodule

### hdl/extendible_hash_join_table_unit.sv
// Top level: extendible hash join table with directory, bucket and slot memories
//
//  channel    | dir | tdata                      | tuser         | tlast
//  -----------+-----+----------------------------+---------------+-------------
//  s_axis     | in  | [31:0] key, [63:32] value  | [0] func      | -
//  m_axis     | out | [31:0] match_value         | [2:0] status  | last
//
// One item at a time. A probe hashes the key, then reads the stored slots
// (hash unit one byte a cycle, then directory, bucket and slot memory reads).
// An insert into a free slot takes the same hash, directory and bucket steps; a
// split copies each directory entry when the directory doubles, scans every
// directory entry, and redistributes each slot of the split bucket.
// After reset a clearing pass over the bucket pool initializes the bucket and
// directory memories; s_axis is not ready during it.
// A stalled m_axis holds the sequencer at the point where it emits a result.
module extendible_hash_join_table_unit #(
    parameter int BUCKET_SLOTS  = ehj_pkg::BUCKET_SLOTS_DEF,
    parameter int MAX_DEPTH     = ehj_pkg::MAX_DEPTH_DEF,
    parameter int BUCKET_POOL   = ehj_pkg::BUCKET_POOL_DEF,
    parameter int INITIAL_DEPTH = ehj_pkg::INITIAL_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [31:0] key, [63:32] value
    input  logic        i_s_axis_tuser,   // [0] func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] match_value
    output logic [2:0]  o_m_axis_tuser,   // [2:0] status
    output logic        o_m_axis_tlast
);

    localparam int BW  = $clog2(BUCKET_POOL);
    localparam int NFW = $clog2(BUCKET_POOL + 1);
    localparam int PW  = MAX_DEPTH + 1;
    localparam int FW  = $clog2(BUCKET_SLOTS + 1);
    localparam int SW  = $clog2(BUCKET_SLOTS);
    localparam int DW  = MAX_DEPTH;
    localparam int GW  = $clog2(MAX_DEPTH + 1);
    localparam int IW  = ((DW > BW) ? DW : BW) + 1;
    localparam int CW  = ((PW > NFW) ? PW : NFW) + 1;
    localparam int EW  = FW + PW;
    localparam int NW  = $clog2(ehj_pkg::MAX_RESULTS + 1);
    localparam int D0  = ehj_pkg::fit_depth(INITIAL_DEPTH, MAX_DEPTH, BUCKET_POOL);
    localparam int NI  = 1 << D0;
    localparam int DIR_DEPTH = 1 << MAX_DEPTH;
    localparam int KV_DEPTH  = BUCKET_POOL << SW;

    ehj_pkg::t_state r_state, n_state;

    // item registers
    logic            r_func, n_func;
    logic [31:0]     r_key, n_key;
    logic [31:0]     r_val, n_val;
    logic [31:0]     r_hkey, n_hkey;
    // table registers
    logic [GW-1:0]   r_gd, n_gd;
    logic [NFW-1:0]  r_nfb, n_nfb;
    // sequencer registers
    logic [IW-1:0]   r_i, n_i;
    logic [IW-1:0]   r_old, n_old;
    logic [BW-1:0]   r_b, n_b;
    logic [BW-1:0]   r_q, n_q;
    logic            r_seen, n_seen;
    logic [FW-1:0]   r_j, n_j;
    logic [FW-1:0]   r_fill, n_fill;
    logic [NW-1:0]   r_n, n_n;
    logic            r_have, n_have;
    logic [31:0]     r_pend, n_pend;
    logic [63:0]     r_slot_buf [BUCKET_SLOTS];
    logic            buf_we;
    // output register
    logic            r_ov;
    logic [2:0]      r_osts;
    logic [31:0]     r_oval;
    logic            r_olast;

    // memory ports
    logic            dir_we, dir_re;
    logic [DW-1:0]   dir_wa, dir_ra, dir_wd_i;
    logic [BW-1:0]   dir_wd, dir_rd;
    logic            bkt_we, bkt_re;
    logic [BW-1:0]   bkt_wa, bkt_ra;
    logic [EW-1:0]   bkt_wd, bkt_rd;
    logic            kv_we, kv_re;
    logic [BW+SW-1:0] kv_wa, kv_ra;
    logic [63:0]     kv_wd, kv_rd;

    // hash unit
    logic            hash_start;
    logic [31:0]     hash_key;
    ehj_pkg::t_hash_rsp hash_rsp;

    // emit request
    logic            emit;
    logic [2:0]      e_sts;
    logic [31:0]     e_val;
    logic            e_last;
    logic            out_free;

    // derived values
    logic [DW-1:0]   dir_mask;
    logic [IW-1:0]   dir_size;
    logic [FW-1:0]   q_fill;
    logic [PW-1:0]   q_pcnt;
    logic            grow;
    logic [CW-1:0]   need;
    logic            pool_short;
    logic            in_acc;

    assign dir_wd_i = '0;

    ehj_ram #(.DEPTH(DIR_DEPTH), .AW(DW), .DW(BW)) u_dir (
        .i_clk(i_clk), .i_we(dir_we), .i_wa(dir_wa), .i_wd(dir_wd),
        .i_re(dir_re), .i_ra(dir_ra | dir_wd_i), .o_rd(dir_rd)
    );

    ehj_ram #(.DEPTH(BUCKET_POOL), .AW(BW), .DW(EW)) u_bkt (
        .i_clk(i_clk), .i_we(bkt_we), .i_wa(bkt_wa), .i_wd(bkt_wd),
        .i_re(bkt_re), .i_ra(bkt_ra), .o_rd(bkt_rd)
    );

    ehj_ram #(.DEPTH(KV_DEPTH), .AW(BW + SW), .DW(64)) u_kv (
        .i_clk(i_clk), .i_we(kv_we), .i_wa(kv_wa), .i_wd(kv_wd),
        .i_re(kv_re), .i_ra(kv_ra), .o_rd(kv_rd)
    );

    ehj_hash u_hash (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(hash_start),
        .i_key(hash_key), .o_rsp(hash_rsp)
    );

    // low global-depth bits of a hash
    always_comb begin
        for (int k = 0; k < DW; k++) begin
            dir_mask[k] = (k < int'(r_gd));
        end
    end

    assign dir_size   = IW'(1) << r_gd;
    assign q_fill     = bkt_rd[EW-1:PW];
    assign q_pcnt     = bkt_rd[PW-1:0];
    assign grow       = (q_pcnt == PW'(1));
    assign need       = grow ? CW'(1) : CW'(q_pcnt - PW'(1));
    assign pool_short = (CW'(r_nfb) > CW'(BUCKET_POOL))
                     || (need > (CW'(BUCKET_POOL) - CW'(r_nfb)));
    assign out_free   = !r_ov || i_m_axis_tready;
    assign in_acc     = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ehj_pkg::ST_IDLE);

    // sequencer: next state and memory controls
    always_comb begin
        n_state = r_state;
        n_func  = r_func;
        n_key   = r_key;
        n_val   = r_val;
        n_hkey  = r_hkey;
        n_gd    = r_gd;
        n_nfb   = r_nfb;
        n_i     = r_i;
        n_old   = r_old;
        n_b     = r_b;
        n_q     = r_q;
        n_seen  = r_seen;
        n_j     = r_j;
        n_fill  = r_fill;
        n_n     = r_n;
        n_have  = r_have;
        n_pend  = r_pend;
        buf_we  = 1'b0;
        dir_we  = 1'b0;
        dir_wa  = '0;
        dir_wd  = '0;
        dir_re  = 1'b0;
        dir_ra  = '0;
        bkt_we  = 1'b0;
        bkt_wa  = '0;
        bkt_wd  = '0;
        bkt_re  = 1'b0;
        bkt_ra  = '0;
        kv_we   = 1'b0;
        kv_wa   = '0;
        kv_wd   = '0;
        kv_re   = 1'b0;
        kv_ra   = '0;
        hash_start = 1'b0;
        hash_key   = r_slot_buf[r_j[SW-1:0]][31:0];
        emit    = 1'b0;
        e_sts   = ehj_pkg::STS_INSERTED;
        e_val   = '0;
        e_last  = 1'b1;

        case (r_state)
            // initialize bucket table and starting directory
            ehj_pkg::ST_CLEAR: begin
                bkt_we = 1'b1;
                bkt_wa = r_i[BW-1:0];
                bkt_wd = {FW'(0), (r_i < IW'(NI)) ? PW'(1) : PW'(0)};
                if (r_i < IW'(NI)) begin
                    dir_we = 1'b1;
                    dir_wa = r_i[DW-1:0];
                    dir_wd = r_i[BW-1:0];
                end
                n_i = r_i + IW'(1);
                if (r_i == IW'(BUCKET_POOL - 1)) begin
                    n_state = ehj_pkg::ST_IDLE;
                end
            end

            ehj_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_func     = i_s_axis_tuser;
                    n_key      = i_s_axis_tdata[31:0];
                    n_val      = i_s_axis_tdata[63:32];
                    hash_start = 1'b1;
                    hash_key   = i_s_axis_tdata[31:0];
                    n_state    = ehj_pkg::ST_HASH;
                end
            end

            ehj_pkg::ST_HASH: begin
                if (hash_rsp.done) begin
                    n_hkey  = hash_rsp.hash;
                    dir_re  = 1'b1;
                    dir_ra  = hash_rsp.hash[DW-1:0] & dir_mask;
                    n_state = ehj_pkg::ST_DIR;
                end
            end

            // re-walk after a split
            ehj_pkg::ST_RETRY: begin
                dir_re  = 1'b1;
                dir_ra  = r_hkey[DW-1:0] & dir_mask;
                n_state = ehj_pkg::ST_DIR;
            end

            ehj_pkg::ST_DIR: begin
                n_b     = dir_rd;
                bkt_re  = 1'b1;
                bkt_ra  = dir_rd;
                n_state = ehj_pkg::ST_BKT;
            end

            // bucket header in hand: insert, split, drop or start a probe
            ehj_pkg::ST_BKT: begin
                if (r_func == ehj_pkg::FUNC_PROBE) begin
                    n_fill  = q_fill;
                    n_j     = '0;
                    n_n     = '0;
                    n_have  = 1'b0;
                    n_state = ehj_pkg::ST_PROBE_RD;
                end else if (q_fill < FW'(BUCKET_SLOTS)) begin
                    if (out_free) begin
                        kv_we   = 1'b1;
                        kv_wa   = {r_b, q_fill[SW-1:0]};
                        kv_wd   = {r_val, r_key};
                        bkt_we  = 1'b1;
                        bkt_wa  = r_b;
                        bkt_wd  = {q_fill + FW'(1), q_pcnt};
                        emit    = 1'b1;
                        e_sts   = ehj_pkg::STS_INSERTED;
                        n_state = ehj_pkg::ST_IDLE;
                    end
                end else if (grow && (r_gd >= GW'(MAX_DEPTH))) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        e_sts   = ehj_pkg::STS_DEPTH;
                        n_state = ehj_pkg::ST_IDLE;
                    end
                end else if (pool_short) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        e_sts   = ehj_pkg::STS_POOL;
                        n_state = ehj_pkg::ST_IDLE;
                    end
                end else if (grow) begin
                    n_old   = dir_size;
                    n_i     = dir_size;
                    n_state = ehj_pkg::ST_GROW_RD;
                end else begin
                    n_i     = '0;
                    n_seen  = 1'b0;
                    n_state = ehj_pkg::ST_SCAN_RD;
                end
            end

            // directory doubling: copy lower twin, bump its pointer count
            ehj_pkg::ST_GROW_RD: begin
                dir_re  = 1'b1;
                dir_ra  = DW'(r_i - r_old);
                n_state = ehj_pkg::ST_GROW_WT;
            end

            ehj_pkg::ST_GROW_WT: begin
                dir_we  = 1'b1;
                dir_wa  = r_i[DW-1:0];
                dir_wd  = dir_rd;
                bkt_re  = 1'b1;
                bkt_ra  = dir_rd;
                n_q     = dir_rd;
                n_state = ehj_pkg::ST_GROW_INC;
            end

            ehj_pkg::ST_GROW_INC: begin
                bkt_we = 1'b1;
                bkt_wa = r_q;
                bkt_wd = {q_fill, q_pcnt + PW'(1)};
                n_i    = r_i + IW'(1);
                if ((r_i + IW'(1)) == (r_old << 1)) begin
                    n_gd    = r_gd + GW'(1);
                    n_i     = '0;
                    n_seen  = 1'b0;
                    n_state = ehj_pkg::ST_SCAN_RD;
                end else begin
                    n_state = ehj_pkg::ST_GROW_RD;
                end
            end

            // hand every pointer to the split bucket but the lowest a fresh bucket
            ehj_pkg::ST_SCAN_RD: begin
                dir_re  = 1'b1;
                dir_ra  = r_i[DW-1:0];
                n_state = ehj_pkg::ST_SCAN_WT;
            end

            ehj_pkg::ST_SCAN_WT: begin
                if (dir_rd == r_b) begin
                    if (r_seen) begin
                        dir_we = 1'b1;
                        dir_wa = r_i[DW-1:0];
                        dir_wd = r_nfb[BW-1:0];
                        bkt_we = 1'b1;
                        bkt_wa = r_nfb[BW-1:0];
                        bkt_wd = {FW'(0), PW'(1)};
                        n_nfb  = r_nfb + NFW'(1);
                    end
                    n_seen = 1'b1;
                end
                n_i = r_i + IW'(1);
                if ((r_i + IW'(1)) == dir_size) begin
                    n_j     = '0;
                    n_state = ehj_pkg::ST_LOAD_RD;
                end else begin
                    n_state = ehj_pkg::ST_SCAN_RD;
                end
            end

            // pull the old slots into the local buffer
            ehj_pkg::ST_LOAD_RD: begin
                kv_re   = 1'b1;
                kv_ra   = {r_b, r_j[SW-1:0]};
                n_state = ehj_pkg::ST_LOAD_WT;
            end

            ehj_pkg::ST_LOAD_WT: begin
                buf_we = 1'b1;
                if (r_j == FW'(BUCKET_SLOTS - 1)) begin
                    n_state = ehj_pkg::ST_RESET_B;
                end else begin
                    n_j     = r_j + FW'(1);
                    n_state = ehj_pkg::ST_LOAD_RD;
                end
            end

            ehj_pkg::ST_RESET_B: begin
                bkt_we  = 1'b1;
                bkt_wa  = r_b;
                bkt_wd  = {FW'(0), PW'(1)};
                n_j     = '0;
                n_state = ehj_pkg::ST_RH_START;
            end

            // redistribute one buffered slot
            ehj_pkg::ST_RH_START: begin
                hash_start = 1'b1;
                n_state    = ehj_pkg::ST_RH_WAIT;
            end

            ehj_pkg::ST_RH_WAIT: begin
                if (hash_rsp.done) begin
                    dir_re  = 1'b1;
                    dir_ra  = hash_rsp.hash[DW-1:0] & dir_mask;
                    n_state = ehj_pkg::ST_RH_DIR;
                end
            end

            ehj_pkg::ST_RH_DIR: begin
                n_q     = dir_rd;
                bkt_re  = 1'b1;
                bkt_ra  = dir_rd;
                n_state = ehj_pkg::ST_RH_BKT;
            end

            ehj_pkg::ST_RH_BKT: begin
                kv_we  = 1'b1;
                kv_wa  = {r_q, q_fill[SW-1:0]};
                kv_wd  = r_slot_buf[r_j[SW-1:0]];
                bkt_we = 1'b1;
                bkt_wa = r_q;
                bkt_wd = {q_fill + FW'(1), q_pcnt};
                if (r_j == FW'(BUCKET_SLOTS - 1)) begin
                    n_state = ehj_pkg::ST_RETRY;
                end else begin
                    n_j     = r_j + FW'(1);
                    n_state = ehj_pkg::ST_RH_START;
                end
            end

            // probe scan; one match is held back to know which is last
            ehj_pkg::ST_PROBE_RD: begin
                if ((r_j < r_fill) && (r_n < NW'(ehj_pkg::MAX_RESULTS))) begin
                    kv_re   = 1'b1;
                    kv_ra   = {r_b, r_j[SW-1:0]};
                    n_state = ehj_pkg::ST_PROBE_CMP;
                end else begin
                    n_state = ehj_pkg::ST_PROBE_FIN;
                end
            end

            ehj_pkg::ST_PROBE_CMP: begin
                if (kv_rd[31:0] == r_key) begin
                    if (!r_have || out_free) begin
                        if (r_have) begin
                            emit   = 1'b1;
                            e_sts  = ehj_pkg::STS_MATCH;
                            e_val  = r_pend;
                            e_last = 1'b0;
                        end
                        n_pend  = kv_rd[63:32];
                        n_have  = 1'b1;
                        n_n     = r_n + NW'(1);
                        n_j     = r_j + FW'(1);
                        n_state = ehj_pkg::ST_PROBE_RD;
                    end
                end else begin
                    n_j     = r_j + FW'(1);
                    n_state = ehj_pkg::ST_PROBE_RD;
                end
            end

            ehj_pkg::ST_PROBE_FIN: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_sts   = r_have ? ehj_pkg::STS_MATCH : ehj_pkg::STS_NOMATCH;
                    e_val   = r_have ? r_pend : 32'd0;
                    n_state = ehj_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = ehj_pkg::ST_IDLE;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ehj_pkg::ST_CLEAR;
            r_i     <= '0;
            r_gd    <= GW'(D0);
            r_nfb   <= NFW'(NI);
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_gd    <= n_gd;
            r_nfb   <= n_nfb;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_func <= n_func;
        r_key  <= n_key;
        r_val  <= n_val;
        r_hkey <= n_hkey;
        r_old  <= n_old;
        r_b    <= n_b;
        r_q    <= n_q;
        r_seen <= n_seen;
        r_j    <= n_j;
        r_fill <= n_fill;
        r_n    <= n_n;
        r_have <= n_have;
        r_pend <= n_pend;
        if (buf_we) begin
            r_slot_buf[r_j[SW-1:0]] <= kv_rd;
        end
        if (emit) begin
            r_osts  <= e_sts;
            r_oval  <= e_val;
            r_olast <= e_last;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_oval;
    assign o_m_axis_tuser  = r_osts;
    assign o_m_axis_tlast  = r_olast;

`include "extendible_hash_join_table_unit_assert.svh"

    `EHJ_CHECK(a_gd_max, 1'b1, r_gd <= GW'(MAX_DEPTH), "global depth above limit")
    `EHJ_CHECK(a_pool_max, 1'b1, r_nfb <= NFW'(BUCKET_POOL), "bucket pool overrun")
    `EHJ_CHECK_NEXT(a_acc_hash, in_acc, r_state == ehj_pkg::ST_HASH, "accept did not start hash")
    `EHJ_CHECK(a_emit_free, emit, out_free, "result emitted into a full output register")

endmodule

### test/extendible_hash_join_table_unit_test.sv
// Self-checking stimulus and scoreboard for the extendible hash join table unit
module extendible_hash_join_table_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS    = ehj_pkg::BUCKET_SLOTS_DEF;
    localparam int DEPTH_MX = ehj_pkg::MAX_DEPTH_DEF;
    localparam int POOL     = ehj_pkg::BUCKET_POOL_DEF;
    localparam int DIR_N    = 1 << DEPTH_MX;
    localparam int N_RANDOM = 240;
    localparam int WDOG_MAX = 200000;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
        logic        last;
    } t_join_res;

    typedef struct packed {
        logic        func;
        logic [31:0] key;
        logic [31:0] value;
        logic        typed;   // row carries a typed-in result
        logic [2:0]  status;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata;   // [31:0] key, [63:32] value
    logic        i_s_axis_tuser;   // [0] func
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;   // [31:0] match_value
    logic [2:0]  o_m_axis_tuser;   // [2:0] status
    logic        o_m_axis_tlast;

    extendible_hash_join_table_unit uut (.*);

    // shadow copy of the table
    int unsigned tbl_dir [DIR_N];
    int unsigned tbl_gdepth;
    int unsigned tbl_fill [POOL];
    int unsigned tbl_ptrs [POOL];
    logic [31:0] tbl_keys [POOL*SLOTS];
    logic [31:0] tbl_vals [POOL*SLOTS];
    int unsigned tbl_next;

    t_join_res pending_res[$];
    logic [31:0] used_keys[$];
    bit          failed;
    bit          quiet_rx;
    int          wdog;

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    function automatic logic [31:0] sdbm(input logic [31:0] k);
        logic [31:0] h;
        logic [31:0] c;
        h = 32'd0;
        for (int i = 0; i < 4; i++) begin
            c = (k >> (8 * i)) & 32'hFF;
            if (c == 32'd0) break;
            h = c + (h << 6) + (h << 16) - h;
        end
        return h;
    endfunction

    function automatic int unsigned slot_of(input logic [31:0] h);
        return h & ((32'd1 << tbl_gdepth) - 32'd1);
    endfunction

    function automatic void table_reset();
        tbl_gdepth = ehj_pkg::fit_depth(ehj_pkg::INITIAL_DEPTH_DEF, DEPTH_MX, POOL);
        foreach (tbl_dir[i]) tbl_dir[i] = 0;
        foreach (tbl_fill[i]) begin
            tbl_fill[i] = 0;
            tbl_ptrs[i] = 0;
        end
        for (int i = 0; i < (1 << tbl_gdepth); i++) begin
            tbl_dir[i] = i;
            tbl_ptrs[i] = 1;
        end
        tbl_next = 1 << tbl_gdepth;
    endfunction

    function automatic void bucket_put(input int unsigned b, input logic [31:0] k,
                                       input logic [31:0] v);
        if (tbl_fill[b] >= SLOTS) return;
        tbl_keys[b*SLOTS + tbl_fill[b]] = k;
        tbl_vals[b*SLOTS + tbl_fill[b]] = v;
        tbl_fill[b]++;
    endfunction

    // split bucket b, returns STS_INSERTED on success or a drop status
    function automatic logic [2:0] bucket_split(input int unsigned b);
        int unsigned need, old, seen, n;
        bit grow;
        logic [31:0] ks [SLOTS];
        logic [31:0] vs [SLOTS];
        grow = (tbl_ptrs[b] == 1);
        if (grow) begin
            if (tbl_gdepth >= DEPTH_MX) return ehj_pkg::STS_DEPTH;
            need = 1;
        end else begin
            need = tbl_ptrs[b] - 1;
        end
        if (tbl_next > POOL || need > POOL - tbl_next) return ehj_pkg::STS_POOL;
        if (grow) begin
            old = 1 << tbl_gdepth;
            for (int unsigned i = old; i < 2*old; i++) begin
                tbl_dir[i] = tbl_dir[i-old];
                tbl_ptrs[tbl_dir[i]]++;
            end
            tbl_gdepth++;
        end
        seen = 0;
        for (int unsigned i = 0; i < (1 << tbl_gdepth); i++) begin
            if (tbl_dir[i] == b) begin
                seen++;
                if (seen > 1) begin
                    tbl_fill[tbl_next] = 0;
                    tbl_ptrs[tbl_next] = 1;
                    tbl_dir[i] = tbl_next;
                    tbl_next++;
                end
            end
        end
        n = tbl_fill[b];
        for (int i = 0; i < SLOTS; i++) begin
            ks[i] = tbl_keys[b*SLOTS + i];
            vs[i] = tbl_vals[b*SLOTS + i];
        end
        tbl_fill[b] = 0;
        tbl_ptrs[b] = 1;
        for (int unsigned i = 0; i < n; i++)
            bucket_put(tbl_dir[slot_of(sdbm(ks[i]))], ks[i], vs[i]);
        return ehj_pkg::STS_INSERTED;
    endfunction

    // work out the results of one item and queue them
    function automatic void predict_join(input logic func, input logic [31:0] key,
                                         input logic [31:0] val);
        logic [31:0] h;
        logic [2:0] st;
        int unsigned b;
        int n;
        t_join_res r;
        h = sdbm(key);
        if (func == ehj_pkg::FUNC_INSERT) begin
            st = ehj_pkg::STS_INSERTED;
            forever begin
                b = tbl_dir[slot_of(h)];
                if (tbl_fill[b] < SLOTS) begin
                    bucket_put(b, key, val);
                    break;
                end
                st = bucket_split(b);
                if (st != ehj_pkg::STS_INSERTED) break;
            end
            r = '{status: st, value: 32'd0, last: 1'b1};
            pending_res.push_back(r);
            return;
        end
        b = tbl_dir[slot_of(h)];
        n = 0;
        for (int unsigned i = 0; i < tbl_fill[b] && n < ehj_pkg::MAX_RESULTS; i++) begin
            if (tbl_keys[b*SLOTS + i] == key) begin
                r = '{status: ehj_pkg::STS_MATCH, value: tbl_vals[b*SLOTS + i],
                      last: 1'b0};
                pending_res.push_back(r);
                n++;
            end
        end
        if (n == 0) begin
            r = '{status: ehj_pkg::STS_NOMATCH, value: 32'd0, last: 1'b1};
            pending_res.push_back(r);
        end else begin
            pending_res[pending_res.size()-1].last = 1'b1;
        end
    endfunction

    // result side: random stall, check each beat
    always @(posedge i_clk) begin
        t_join_res got, want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= quiet_rx ? 1'b1 : ($urandom_range(99) >= 32);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = '{status: o_m_axis_tuser, value: o_m_axis_tdata,
                        last: o_m_axis_tlast};
                if (pending_res.size() == 0) begin
                    $display("%0t: unexpected result %h", $realtime, got);
                    failed = 1'b1;
                end else begin
                    want = pending_res.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $realtime,
                                 want.status, got.status);
                        failed = 1'b1;
                    end
                    if (got.value !== want.value) begin
                        $display("%0t: match_value expected %h actual %h", $realtime,
                                 want.value, got.value);
                        failed = 1'b1;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: last expected %0b actual %0b", $realtime,
                                 want.last, got.last);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            wdog <= 0;
        end else begin
            wdog <= wdog + 1;
            if (wdog >= WDOG_MAX) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // send one beat, hold valid until accepted; valid stays up for a follow-on beat
    task automatic send_join(input logic func, input logic [31:0] key,
                             input logic [31:0] val, input bit gaps);
        while (gaps && $urandom_range(99) < 32) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= func;
        i_s_axis_tdata  <= {val, key};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_join(func, key, val);
        used_keys.push_back(key);
    endtask

    task automatic drain_all();
        while (pending_res.size() != 0) @(posedge i_clk);
    endtask

    t_stim_row stim_rows[$];

    function automatic t_stim_row row(input logic f, input logic [31:0] k,
                                      input logic [31:0] v, input logic t,
                                      input logic [2:0] s);
        return '{func: f, key: k, value: v, typed: t, status: s};
    endfunction

    initial begin
        logic [31:0] k, v;
        int pick;
        failed = 1'b0;
        quiet_rx = 1'b0;
        wdog = 0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = 1'b0;
        i_m_axis_tready = 1'b0;
        table_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows: empty probe, extremes, duplicates past one bucket
        stim_rows.push_back(row(ehj_pkg::FUNC_PROBE, 32'h0, 32'h0, 1'b1,
                                ehj_pkg::STS_NOMATCH));
        stim_rows.push_back(row(ehj_pkg::FUNC_INSERT, 32'h0, 32'hFFFFFFFF, 1'b1,
                                ehj_pkg::STS_INSERTED));
        stim_rows.push_back(row(ehj_pkg::FUNC_PROBE, 32'h0, 32'h0, 1'b0,
                                ehj_pkg::STS_INSERTED));
        stim_rows.push_back(row(ehj_pkg::FUNC_INSERT, 32'h80000000, 32'h80000000, 1'b1,
                                ehj_pkg::STS_INSERTED));
        stim_rows.push_back(row(ehj_pkg::FUNC_INSERT, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1,
                                ehj_pkg::STS_INSERTED));
        stim_rows.push_back(row(ehj_pkg::FUNC_INSERT, 32'hFFFFFFFF, 32'h00000001, 1'b1,
                                ehj_pkg::STS_INSERTED));
        stim_rows.push_back(row(ehj_pkg::FUNC_PROBE, 32'hFFFFFFFF, 32'hDEADBEEF, 1'b0,
                                ehj_pkg::STS_INSERTED));
        stim_rows.push_back(row(ehj_pkg::FUNC_PROBE, 32'h7FFFFFFF, 32'h0, 1'b0,
                                ehj_pkg::STS_INSERTED));
        // ten copies of one key: probe cap, then depth-limit drop
        for (int i = 0; i < 10; i++)
            stim_rows.push_back(row(ehj_pkg::FUNC_INSERT, 32'h00000055, 32'(i), 1'b0,
                                    ehj_pkg::STS_INSERTED));
        stim_rows.push_back(row(ehj_pkg::FUNC_PROBE, 32'h00000055, 32'h0, 1'b0,
                                ehj_pkg::STS_INSERTED));
        stim_rows.push_back(row(ehj_pkg::FUNC_PROBE, 32'h80000000, 32'h0, 1'b0,
                                ehj_pkg::STS_INSERTED));
        stim_rows.push_back(row(ehj_pkg::FUNC_PROBE, 32'h12345678, 32'h0, 1'b1,
                                ehj_pkg::STS_NOMATCH));

        foreach (stim_rows[i]) begin
            send_join(stim_rows[i].func, stim_rows[i].key, stim_rows[i].value, 1);
            if (stim_rows[i].typed &&
                pending_res[pending_res.size()-1].status !== stim_rows[i].status) begin
                $display("%0t: row %0d typed status %0d predicted %0d", $realtime, i,
                         stim_rows[i].status, pending_res[pending_res.size()-1].status);
                failed = 1'b1;
            end
        end
        i_s_axis_tvalid <= 1'b0;

        // sender holds off until the table has answered everything
        drain_all();

        // random: mostly inserts to drive splits, known keys reused for inserts and probes alike
        for (int n = 0; n < N_RANDOM; n++) begin
            quiet_rx = (n >= 100 && n < 140);
            pick = $urandom_range(99);
            v = $urandom();
            if (pick < 15) k = $urandom_range(255);
            else if (pick < 25) k = $urandom() | 32'h80808080;
            else k = $urandom();
            if ($urandom_range(99) < 40 && used_keys.size() != 0)
                k = used_keys[$urandom_range(used_keys.size()-1)];
            send_join($urandom_range(99) < 60 ? ehj_pkg::FUNC_INSERT : ehj_pkg::FUNC_PROBE,
                      k, v, !quiet_rx);
        end
        i_s_axis_tvalid <= 1'b0;
        quiet_rx = 1'b0;

        drain_all();
        repeat (200) @(posedge i_clk);
        if (!failed && pending_res.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
